[rtl/core/u32x_pkg.sv]
// Shared constants, types and the code point encoder of the UTF-32 transcoder.
package u32x_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;
  localparam int BYTE_W     = 8;
  localparam int UNIT_W     = 16;
  localparam int CP_W       = 21;
  localparam int MAX_UNITS  = 4;
  localparam int UNIT_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UTF16_OUTPUT = 2'd1;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [31:0]     MAX_CP         = 32'h0010FFFF;
  localparam logic [31:0]     SURR_LO        = 32'h0000D800;
  localparam logic [31:0]     SURR_HI        = 32'h0000DFFF;

  typedef struct packed {
    logic big_endian;
    logic utf16_output;
  } cfg_t;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            replaced;
  } point_t;

  typedef struct packed {
    logic [MAX_UNITS-1:0][UNIT_W-1:0] units;
    logic [UNIT_IDX_W-1:0]            last_idx;
  } units_t;

  // Split one code point into UTF-8 bytes or UTF-16 units
  function automatic units_t encode_point(input logic [CP_W-1:0] cp, input logic utf16);
    units_t    res;
    logic [19:0] v;
    res = '0;
    v   = cp[19:0] - 20'h10000;
    if (utf16) begin
      if (cp < 21'h010000) begin
        res.units[0] = cp[15:0];
        res.last_idx = 2'd0;
      end else begin
        res.units[0] = 16'hD800 | {6'd0, v[19:10]};
        res.units[1] = 16'hDC00 | {6'd0, v[9:0]};
        res.last_idx = 2'd1;
      end
    end else begin
      if (cp < 21'h000080) begin
        res.units[0] = {8'd0, 1'b0, cp[6:0]};
        res.last_idx = 2'd0;
      end else if (cp < 21'h000800) begin
        res.units[0] = {8'd0, 3'b110, cp[10:6]};
        res.units[1] = {8'd0, 2'b10, cp[5:0]};
        res.last_idx = 2'd1;
      end else if (cp < 21'h010000) begin
        res.units[0] = {8'd0, 4'b1110, cp[15:12]};
        res.units[1] = {8'd0, 2'b10, cp[11:6]};
        res.units[2] = {8'd0, 2'b10, cp[5:0]};
        res.last_idx = 2'd2;
      end else begin
        res.units[0] = {8'd0, 5'b11110, cp[20:18]};
        res.units[1] = {8'd0, 2'b10, cp[17:12]};
        res.units[2] = {8'd0, 2'b10, cp[11:6]};
        res.units[3] = {8'd0, 2'b10, cp[5:0]};
        res.last_idx = 2'd3;
      end
    end
    return res;
  endfunction

endpackage

[rtl/core/u32x_in_if.sv]
// Input byte channel of the transcoder.
interface u32x_in_if;
  logic                          valid;
  logic                          ready;
  logic [u32x_pkg::BYTE_W-1:0]   data_byte;
  logic                          end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

[rtl/core/u32x_out_if.sv]
// Result channel of the transcoder: one UTF-8 byte or UTF-16 unit per transaction.
interface u32x_out_if;
  logic                          valid;
  logic                          ready;
  logic [u32x_pkg::UNIT_W-1:0]   code_unit;
  logic                          last_of_run;
  logic                          replaced;

  modport source (output valid, output code_unit, output last_of_run, output replaced,
                  input ready);
  modport sink   (input valid, input code_unit, input last_of_run, input replaced,
                  output ready);
endinterface

[rtl/core/u32x_cfg_if.sv]
// Configuration write channel of the transcoder.
interface u32x_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [u32x_pkg::CFG_IDX_W-1:0]   index;
  logic [u32x_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/u32x_cfg_regs.sv]
// Configuration registers: byte order and output form.
module u32x_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  u32x_cfg_if.sink          cfg_ch,
  output u32x_pkg::cfg_t    cfg
);

  u32x_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        u32x_pkg::CFG_BIG_ENDIAN:   cfg_nxt.big_endian   = cfg_ch.data[0];
        u32x_pkg::CFG_UTF16_OUTPUT: cfg_nxt.utf16_output = cfg_ch.data[0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/core/u32x_assembler.sv]
// Byte gatherer: builds code points from four bytes, validates and flushes.
module u32x_assembler (
  input  logic               clk,
  input  logic               rst_n,
  input  u32x_pkg::cfg_t     cfg,
  u32x_in_if.sink            in_ch,
  output logic               pt_valid,
  output u32x_pkg::point_t   pt,
  input  logic               pt_take
);

  logic [1:0]              held_r, held_nxt;
  logic [23:0]             partial_r, partial_nxt;
  logic                    pt_valid_r, pt_valid_nxt;
  u32x_pkg::point_t        pt_r, pt_nxt;
  logic                    accept;
  logic [31:0]             word;
  logic [31:0]             cp32;
  logic                    bad_cp;

  // Point register frees when downstream takes it
  assign in_ch.ready = !pt_valid_r || pt_take;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pt_valid    = pt_valid_r;
  assign pt          = pt_r;

  // Full word in arrival order, then byte order applied
  assign word   = {partial_r, in_ch.data_byte};
  assign cp32   = cfg.big_endian ? word : {word[7:0], word[15:8], word[23:16], word[31:24]};
  assign bad_cp = (cp32 > u32x_pkg::MAX_CP) ||
                  (cp32 inside {[u32x_pkg::SURR_LO:u32x_pkg::SURR_HI]});

  // Next state of the word gatherer and the point register
  always_comb begin
    held_nxt     = held_r;
    partial_nxt  = partial_r;
    pt_valid_nxt = pt_valid_r && !pt_take;
    pt_nxt       = pt_r;
    if (accept) begin
      if (held_r == 2'd3) begin
        held_nxt     = 2'd0;
        partial_nxt  = '0;
        pt_valid_nxt = 1'b1;
        if (bad_cp) begin
          pt_nxt.cp       = u32x_pkg::REPLACEMENT_CP;
          pt_nxt.replaced = 1'b1;
        end else begin
          pt_nxt.cp       = cp32[u32x_pkg::CP_W-1:0];
          pt_nxt.replaced = 1'b0;
        end
      end else if (in_ch.end_of_input) begin
        // input ends inside a word
        held_nxt        = 2'd0;
        partial_nxt     = '0;
        pt_valid_nxt    = 1'b1;
        pt_nxt.cp       = u32x_pkg::REPLACEMENT_CP;
        pt_nxt.replaced = 1'b1;
      end else begin
        held_nxt     = held_r + 2'd1;
        partial_nxt  = {partial_r[15:0], in_ch.data_byte};
        pt_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= '0;
      partial_r  <= '0;
      pt_valid_r <= 1'b0;
    end else begin
      held_r     <= held_nxt;
      partial_r  <= partial_nxt;
      pt_valid_r <= pt_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pt_r <= pt_nxt;
  end

endmodule

[rtl/core/u32x_encoder.sv]
// Encoder and unit buffer: expands a code point and issues one unit per transaction.
module u32x_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  u32x_pkg::cfg_t     cfg,
  input  logic               pt_valid,
  input  u32x_pkg::point_t   pt,
  output logic               pt_take,
  u32x_out_if.source         out_ch
);

  logic                                        buf_valid_r, buf_valid_nxt;
  logic [u32x_pkg::MAX_UNITS-1:0][u32x_pkg::UNIT_W-1:0] units_r, units_nxt;
  logic [u32x_pkg::UNIT_IDX_W-1:0]             last_r, last_nxt;
  logic [u32x_pkg::UNIT_IDX_W-1:0]             idx_r, idx_nxt;
  logic                                        rep_r, rep_nxt;
  logic                                        out_acc;
  logic                                        on_last;
  logic                                        buf_free;
  u32x_pkg::units_t                            enc;

  assign enc      = u32x_pkg::encode_point(pt.cp, cfg.utf16_output);
  assign on_last  = (idx_r == last_r);
  assign out_acc  = out_ch.valid && out_ch.ready;
  assign buf_free = !buf_valid_r || (out_ch.ready && on_last);
  assign pt_take  = pt_valid && buf_free;

  assign out_ch.valid       = buf_valid_r;
  assign out_ch.code_unit   = units_r[idx_r];
  assign out_ch.last_of_run = on_last;
  assign out_ch.replaced    = rep_r;

  // Load a new run when empty or as the last unit leaves, else step through the run
  always_comb begin
    buf_valid_nxt = buf_valid_r;
    units_nxt     = units_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    rep_nxt       = rep_r;
    if (pt_take) begin
      buf_valid_nxt = 1'b1;
      units_nxt     = enc.units;
      last_nxt      = enc.last_idx;
      idx_nxt       = '0;
      rep_nxt       = pt.replaced;
    end else if (out_acc) begin
      if (on_last) begin
        buf_valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      buf_valid_r <= buf_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    units_r <= units_nxt;
    last_r  <= last_nxt;
    rep_r   <= rep_nxt;
  end

endmodule

[rtl/core/utf32_to_utf8_utf16_transcoder.sv]
// Top level of the UTF-32 to UTF-8 / UTF-16 transcoder.
//
// in_ch takes the UTF-32 stream one byte per transaction; every fourth byte
// completes a word that is assembled in the configured byte order. A word
// above U+10FFFF or in the surrogate range becomes U+FFFD with replaced set.
// A byte flagged end_of_input inside a word yields one U+FFFD and clears it.
// out_ch gives one UTF-8 byte or UTF-16 unit per transaction; last_of_run
// marks the final unit caused by an input byte.
// cfg_ch writes big_endian (index 0) and utf16_output (index 1); it is always
// ready; the user writes it only while no transaction is in flight (unenforced).
// A completing byte passes the point register, then the unit buffer, before
// its first unit shows. One byte per cycle is accepted while the point
// register is free or being taken; each code point leaves the unit buffer
// at one unit per cycle while out_ch is ready, which sets the output rate.
// Reset (rst_n low, synchronous) clears the configuration, any partial word
// and all buffered units. When out_ch stalls, the unit buffer and then the
// point register hold, and in_ch drops ready once both are full.
module utf32_to_utf8_utf16_transcoder (
  input  logic        clk,
  input  logic        rst_n,
  u32x_in_if.sink     in_ch,
  u32x_out_if.source  out_ch,
  u32x_cfg_if.sink    cfg_ch
);

  u32x_pkg::cfg_t   cfg;
  logic             pt_valid;
  logic             pt_take;
  u32x_pkg::point_t pt;

  u32x_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  u32x_assembler u_asm (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_ch    (in_ch),
    .pt_valid (pt_valid),
    .pt       (pt),
    .pt_take  (pt_take)
  );

  u32x_encoder u_enc (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .pt_valid (pt_valid),
    .pt       (pt),
    .pt_take  (pt_take),
    .out_ch   (out_ch)
  );

endmodule

[rtl/core/u32x_checker.sv]
// Port-level assertions for the transcoder and their bind to the top level.
module u32x_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_code_unit,
  input logic        out_last_of_run,
  input logic        out_replaced
);

  localparam logic [15:0] REP_U16 = 16'hFFFD;
  localparam logic [15:0] REP_B0  = 16'h00EF;
  localparam logic [15:0] REP_B1  = 16'h00BF;
  localparam logic [15:0] REP_B2  = 16'h00BD;

  logic [1:0] run_cnt_r;
  logic       out_acc;

  assign out_acc = out_valid && out_ready;

  // Units issued so far in the current run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r <= '0;
    end else if (out_acc) begin
      run_cnt_r <= out_last_of_run ? 2'd0 : run_cnt_r + 2'd1;
    end
  end

  // No run is longer than four units
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && (run_cnt_r == 2'd3) |-> out_last_of_run)
    else $error("run exceeds four units");

  // A replaced unit is part of U+FFFD in either form
  a_rep_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_replaced |->
      (out_code_unit == REP_U16) || (out_code_unit == REP_B0) ||
      (out_code_unit == REP_B1) || (out_code_unit == REP_B2))
    else $error("replaced unit is not part of U+FFFD");

  // Nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled unit holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_unit) &&
      $stable(out_last_of_run) && $stable(out_replaced))
    else $error("stalled unit changed");

endmodule

bind utf32_to_utf8_utf16_transcoder u32x_checker u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_code_unit   (out_ch.code_unit),
  .out_last_of_run (out_ch.last_of_run),
  .out_replaced    (out_ch.replaced)
);
